@@ hdl/assert_macros.svh @@
// Assertion macros shared by the execute step RTL.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RVX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RVX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rvx_pkg.sv @@
// Shared types and constants for the RV32I subset execute step.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rvx_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int WORDS     = MEM_BYTES / 4;
  localparam int WORD_AW   = MEM_AW - 2;
  localparam int NUM_REGS  = 32;
  localparam int REG_AW    = $clog2(NUM_REGS);

  // Input actions.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_EXEC  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_MISPC   = 3'd2;
  localparam logic [2:0] ST_MISACC  = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;
  localparam logic [2:0] ST_HALTED  = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENTRY     = 2'd0;
  localparam logic [1:0] REG_CODE_LOW  = 2'd1;
  localparam logic [1:0] REG_CODE_HIGH = 2'd2;

  localparam logic [31:0] CODE_HIGH_RST = 32'd256;

  typedef enum logic [1:0] {
    K_WRITE,
    K_EXEC,
    K_READ,
    K_NONE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  byte_value;
  } q_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [31:0]       pc_after;
    logic [31:0]       read_word;
    logic              dest_written;
    logic [REG_AW-1:0] dest_index;
    logic [31:0]       dest_value;
  } result_t;

  typedef struct packed {
    logic        pc_load;
    logic [31:0] pc_value;
    logic [31:0] code_low;
    logic [31:0] code_high;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic halted;
  } bk_stat_t;

endpackage

`default_nettype wire

@@ hdl/rvx_front.sv @@
// Front end: accepts input beats, classifies the action and queues them.
// Depends on rvx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvx_front import rvx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_address,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        block_in,
  input  wire logic        pop,
  output logic             head_valid,
  output q_item_t          head
);

  q_item_t    q_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic       push;
  kind_t      kind;

  always_comb begin
    unique case (in_action)
      ACT_WRITE: kind = K_WRITE;
      ACT_EXEC:  kind = K_EXEC;
      ACT_READ:  kind = K_READ;
      ACT_NONE:  kind = K_NONE;
      default:   kind = K_NONE;
    endcase
  end

  assign in_stall   = block_in || (count_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != 2'd0);
  assign head       = q_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= '{kind: kind, address: in_address, byte_value: in_byte_value};
    end
  end

endmodule

`default_nettype wire

@@ hdl/rvx_back.sv @@
// Back end: sequencer that runs queued actions against the byte memory
// and register file and holds the result register. Depends on rvx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvx_back import rvx_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire logic    head_valid,
  input  wire q_item_t head,
  output logic         pop,
  output bk_stat_t     stat,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_res
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_RDA   = 3'd5;
  localparam logic [2:0] S_RDB   = 3'd6;

  localparam logic [6:0] OPC_OPIMM = 7'h13;
  localparam logic [6:0] OPC_LOAD  = 7'h03;
  localparam logic [6:0] OPC_OP    = 7'h33;
  localparam logic [6:0] OPC_LUI   = 7'h37;
  localparam logic [6:0] OPC_AUIPC = 7'h17;
  localparam logic [6:0] OPC_STORE = 7'h23;
  localparam logic [6:0] OPC_JALR  = 7'h67;
  localparam logic [6:0] OPC_JAL   = 7'h6F;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  logic [31:0] mem_r  [WORDS];
  logic [31:0] regs_r [NUM_REGS];

  logic [2:0]         state_r, state_nxt;
  logic [WORD_AW-1:0] clr_r, clr_nxt;
  logic [31:0]        pc_r, pc_nxt;
  logic               halted_r, halted_nxt;
  logic [31:0]        inst_r, inst_nxt;
  logic [31:0]        addr_r, addr_nxt;
  logic [2:0]         f3_r, f3_nxt;
  logic [REG_AW-1:0]  rd_r, rd_nxt;
  logic [31:0]        lo_word_r, lo_word_nxt;
  logic [31:0]        rdata_r;
  logic [31:0]        rs1_q_r, rs2_q_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r, out_nxt;

  logic               mem_we, mem_re, rf_we, rf_re;
  logic [3:0]         mem_be;
  logic [WORD_AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]        mem_wdata;
  logic [REG_AW-1:0]  rf_waddr;
  logic [31:0]        rf_wdata;
  logic               out_free, range_bad;

  // Execute-stage decode.
  logic [6:0]        ex_op, ex_f7;
  logic [2:0]        ex_f3;
  logic [REG_AW-1:0] ex_rd, ex_sh;
  logic [31:0]       ex_immi, ex_imms, ex_immu, ex_immj;
  logic [31:0]       ex_a, ex_b, ex_pc4, ex_v, ex_npc, ex_ld_addr, ex_st_addr;
  logic              ex_ok, ex_load, ex_store, ex_mis;
  logic [3:0]        ex_be;
  logic [31:0]       ex_wdata;

  // Load and word-read alignment.
  logic [31:0] ld_shift, ld_val, rd_word;
  logic [63:0] rd_pair;

  always_comb begin
    ex_op      = inst_r[6:0];
    ex_rd      = inst_r[11:7];
    ex_f3      = inst_r[14:12];
    ex_sh      = inst_r[24:20];
    ex_f7      = inst_r[31:25];
    ex_immi    = {{20{inst_r[31]}}, inst_r[31:20]};
    ex_imms    = {{20{inst_r[31]}}, inst_r[31:25], inst_r[11:7]};
    ex_immu    = {inst_r[31:12], 12'b0};
    ex_immj    = {{12{inst_r[31]}}, inst_r[19:12], inst_r[20], inst_r[30:21], 1'b0};
    ex_a       = rs1_q_r;
    ex_b       = rs2_q_r;
    ex_pc4     = pc_r + 32'd4;
    ex_ld_addr = ex_a + ex_immi;
    ex_st_addr = ex_a + ex_imms;
    ex_v       = 32'd0;
    ex_npc     = ex_pc4;
    ex_ok      = 1'b1;
    ex_load    = 1'b0;
    ex_store   = 1'b0;
    ex_mis     = 1'b0;
    unique case (ex_op)
      OPC_OPIMM: begin
        case (ex_f3)
          F3_ADD:  ex_v = ex_a + ex_immi;
          F3_SLL:  begin
            if (ex_f7 == F7_BASE) ex_v = ex_a << ex_sh;
            else ex_ok = 1'b0;
          end
          F3_SLT:  ex_v = {31'd0, $signed(ex_a) < $signed(ex_immi)};
          F3_SLTU: ex_v = {31'd0, ex_a < ex_immi};
          F3_XOR:  ex_v = ex_a ^ ex_immi;
          F3_SR:   begin
            if (ex_f7 == F7_BASE) ex_v = ex_a >> ex_sh;
            else if (ex_f7 == F7_ALT) ex_v = $unsigned($signed(ex_a) >>> ex_sh);
            else ex_ok = 1'b0;
          end
          F3_OR:   ex_v = ex_a | ex_immi;
          default: ex_v = ex_a & ex_immi;
        endcase
      end
      OPC_OP: begin
        if (ex_f7 == F7_ALT && ex_f3 == F3_ADD) begin
          ex_v = ex_a - ex_b;
        end else if (ex_f7 == F7_ALT && ex_f3 == F3_SR) begin
          ex_v = $unsigned($signed(ex_a) >>> ex_b[4:0]);
        end else if (ex_f7 != F7_BASE) begin
          ex_ok = 1'b0;
        end else begin
          case (ex_f3)
            F3_ADD:  ex_v = ex_a + ex_b;
            F3_SLL:  ex_v = ex_a << ex_b[4:0];
            F3_SLT:  ex_v = {31'd0, $signed(ex_a) < $signed(ex_b)};
            F3_SLTU: ex_v = {31'd0, ex_a < ex_b};
            F3_XOR:  ex_v = ex_a ^ ex_b;
            F3_SR:   ex_v = ex_a >> ex_b[4:0];
            F3_OR:   ex_v = ex_a | ex_b;
            default: ex_v = ex_a & ex_b;
          endcase
        end
      end
      OPC_LOAD: begin
        ex_load = 1'b1;
        if (!(ex_f3 == F3_B || ex_f3 == F3_H || ex_f3 == F3_W ||
              ex_f3 == F3_BU || ex_f3 == F3_HU)) begin
          ex_ok = 1'b0;
        end
        ex_mis = ((ex_f3 == F3_H || ex_f3 == F3_HU) && ex_ld_addr[0]) ||
                 (ex_f3 == F3_W && ex_ld_addr[1:0] != 2'd0);
      end
      OPC_STORE: begin
        ex_store = 1'b1;
        if (!(ex_f3 == F3_B || ex_f3 == F3_H || ex_f3 == F3_W)) ex_ok = 1'b0;
        ex_mis = (ex_f3 == F3_H && ex_st_addr[0]) ||
                 (ex_f3 == F3_W && ex_st_addr[1:0] != 2'd0);
      end
      OPC_LUI:   ex_v = ex_immu;
      OPC_AUIPC: ex_v = pc_r + ex_immu;
      OPC_JALR: begin
        if (ex_f3 != F3_ADD) ex_ok = 1'b0;
        ex_v   = ex_pc4;
        ex_npc = ex_ld_addr & ~32'd1;
      end
      OPC_JAL: begin
        ex_v   = ex_pc4;
        ex_npc = pc_r + ex_immj;
      end
      default: ex_ok = 1'b0;
    endcase

    case (ex_f3)
      F3_B: begin
        ex_be    = 4'b0001 << ex_st_addr[1:0];
        ex_wdata = {4{ex_b[7:0]}};
      end
      F3_H: begin
        ex_be    = 4'b0011 << ex_st_addr[1:0];
        ex_wdata = {2{ex_b[15:0]}};
      end
      default: begin
        ex_be    = 4'b1111;
        ex_wdata = ex_b;
      end
    endcase
  end

  always_comb begin
    ld_shift = rdata_r >> {addr_r[1:0], 3'b000};
    case (f3_r)
      F3_B:    ld_val = {{24{ld_shift[7]}}, ld_shift[7:0]};
      F3_BU:   ld_val = {24'd0, ld_shift[7:0]};
      F3_H:    ld_val = {{16{ld_shift[15]}}, ld_shift[15:0]};
      F3_HU:   ld_val = {16'd0, ld_shift[15:0]};
      default: ld_val = rdata_r;
    endcase
    rd_pair = {rdata_r, lo_word_r} >> {addr_r[1:0], 3'b000};
    rd_word = rd_pair[31:0];
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign range_bad = (pc_r < cfg.code_low) ||
                     (({1'b0, pc_r} + 33'd3) >= {1'b0, cfg.code_high});

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pc_nxt        = pc_r;
    halted_nxt    = halted_r;
    inst_nxt      = inst_r;
    addr_nxt      = addr_r;
    f3_nxt        = f3_r;
    rd_nxt        = rd_r;
    lo_word_nxt   = lo_word_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_be        = 4'b0000;
    mem_waddr     = pc_r[MEM_AW-1:2];
    mem_wdata     = 32'd0;
    mem_re        = 1'b0;
    mem_raddr     = pc_r[MEM_AW-1:2];
    rf_we         = 1'b0;
    rf_re         = 1'b0;
    rf_waddr      = ex_rd;
    rf_wdata      = ex_v;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_be    = 4'b1111;
        mem_waddr = clr_r;
        rf_we     = 1'b1;
        rf_waddr  = clr_r[REG_AW-1:0];
        rf_wdata  = 32'd0;
        clr_nxt   = clr_r + WORD_AW'(1);
        if (clr_r == WORD_AW'(WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (head_valid) begin
          unique case (head.kind)
            K_WRITE: begin
              if (out_free) begin
                pop           = 1'b1;
                mem_we        = 1'b1;
                mem_be        = 4'b0001 << head.address[1:0];
                mem_waddr     = head.address[MEM_AW-1:2];
                mem_wdata     = {4{head.byte_value}};
                out_valid_nxt = 1'b1;
                out_nxt       = '{ST_OK, pc_r, 32'd0, 1'b0, '0, 32'd0};
              end
            end
            K_READ: begin
              pop       = 1'b1;
              mem_re    = 1'b1;
              mem_raddr = head.address[MEM_AW-1:2];
              addr_nxt  = head.address;
              state_nxt = S_RDA;
            end
            K_NONE: begin
              if (out_free) begin
                pop           = 1'b1;
                out_valid_nxt = 1'b1;
                out_nxt       = '{ST_OK, pc_r, 32'd0, 1'b0, '0, 32'd0};
              end
            end
            K_EXEC: begin
              if (halted_r || range_bad || pc_r[1:0] != 2'd0) begin
                if (out_free) begin
                  pop           = 1'b1;
                  out_valid_nxt = 1'b1;
                  halted_nxt    = 1'b1;
                  out_nxt       = '{ST_MISPC, pc_r, 32'd0, 1'b0, '0, 32'd0};
                  if (halted_r) out_nxt.status = ST_HALTED;
                  else if (range_bad) out_nxt.status = ST_RANGE;
                end
              end else begin
                pop       = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = pc_r[MEM_AW-1:2];
                state_nxt = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        inst_nxt  = rdata_r;
        rf_re     = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (ex_ok && !ex_mis && ex_load) begin
          mem_re    = 1'b1;
          mem_raddr = ex_ld_addr[MEM_AW-1:2];
          addr_nxt  = ex_ld_addr;
          f3_nxt    = ex_f3;
          rd_nxt    = ex_rd;
          pc_nxt    = ex_pc4;
          state_nxt = S_LOAD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (!ex_ok || ex_mis) begin
            halted_nxt = 1'b1;
            pc_nxt     = ex_pc4;
            out_nxt    = '{ST_ILLEGAL, ex_pc4, 32'd0, 1'b0, '0, 32'd0};
            if (ex_ok) out_nxt.status = ST_MISACC;
          end else if (ex_store) begin
            mem_we    = 1'b1;
            mem_be    = ex_be;
            mem_waddr = ex_st_addr[MEM_AW-1:2];
            mem_wdata = ex_wdata;
            pc_nxt    = ex_pc4;
            out_nxt   = '{ST_OK, ex_pc4, 32'd0, 1'b0, '0, 32'd0};
          end else begin
            rf_we   = (ex_rd != '0);
            pc_nxt  = ex_npc;
            out_nxt = '{ST_OK, ex_npc, 32'd0, (ex_rd != '0), ex_rd,
                        (ex_rd != '0) ? ex_v : 32'd0};
          end
        end
      end
      S_LOAD: begin
        if (out_free) begin
          rf_we         = (rd_r != '0);
          rf_waddr      = rd_r;
          rf_wdata      = ld_val;
          out_valid_nxt = 1'b1;
          out_nxt       = '{ST_OK, pc_r, 32'd0, (rd_r != '0), rd_r,
                            (rd_r != '0) ? ld_val : 32'd0};
          state_nxt     = S_IDLE;
        end
      end
      S_RDA: begin
        if (addr_r[1:0] == 2'd0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{ST_OK, pc_r, rdata_r, 1'b0, '0, 32'd0};
            state_nxt     = S_IDLE;
          end
        end else begin
          // An unaligned word spans two memory words; fetch the next one.
          lo_word_nxt = rdata_r;
          mem_re      = 1'b1;
          mem_raddr   = addr_r[MEM_AW-1:2] + WORD_AW'(1);
          state_nxt   = S_RDB;
        end
      end
      S_RDB: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{ST_OK, pc_r, rd_word, 1'b0, '0, 32'd0};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Entry writes must arrive only while the block is idle; the block itself does not enforce it.
    if (cfg.pc_load) pc_nxt = cfg.pc_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pc_r        <= 32'd0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pc_r        <= pc_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inst_r    <= inst_nxt;
    addr_r    <= addr_nxt;
    f3_r      <= f3_nxt;
    rd_r      <= rd_nxt;
    lo_word_r <= lo_word_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (mem_we && mem_be[i]) mem_r[mem_waddr][i*8 +: 8] <= mem_wdata[i*8 +: 8];
    end
    if (mem_re) rdata_r <= mem_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rf_we) regs_r[rf_waddr] <= rf_wdata;
    if (rf_re) begin
      rs1_q_r <= regs_r[rdata_r[19:15]];
      rs2_q_r <= regs_r[rdata_r[24:20]];
    end
  end

  assign stat.clearing = (state_r == S_CLEAR);
  assign stat.halted   = halted_r;
  assign out_valid     = out_valid_r;
  assign out_res       = out_r;

endmodule

`default_nettype wire

@@ hdl/rv32i_subset_execute_step.sv @@
// Byte writes, unused actions and faults found before fetch go from the queue head straight
// to the result register; word reads pass S_RDA (and S_RDB if unaligned), execution S_FETCH
// (whose register file read adds a stage) and S_EXEC, loads also S_LOAD. A single memory
// port serves fetch and data, so actions do not overlap. A two-beat queue decouples input
// from execution. After reset a clearing pass zeroes memory and registers; input stalls.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rv32i_subset_execute_step import rvx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_address,
  input  wire logic [7:0]  in_byte_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_pc_after,
  output logic [31:0]      out_read_word,
  output logic             out_dest_written,
  output logic [4:0]       out_dest_index,
  output logic [31:0]      out_dest_value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] entry_r, code_low_r, code_high_r;
  logic        wr_en;
  cfg_t        cfg;
  bk_stat_t    bk_stat;
  logic        pop, head_valid;
  q_item_t     head;
  result_t     res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r     <= 32'd0;
      code_low_r  <= 32'd0;
      code_high_r <= CODE_HIGH_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ENTRY:     entry_r     <= pwdata;
        REG_CODE_LOW:  code_low_r  <= pwdata;
        REG_CODE_HIGH: code_high_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENTRY:     prdata = entry_r;
      REG_CODE_LOW:  prdata = code_low_r;
      REG_CODE_HIGH: prdata = code_high_r;
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg.pc_load   = wr_en && (paddr[3:2] == REG_ENTRY);
  assign cfg.pc_value  = pwdata;
  assign cfg.code_low  = code_low_r;
  assign cfg.code_high = code_high_r;

  rvx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_address    (in_address),
    .in_byte_value (in_byte_value),
    .block_in      (bk_stat.clearing),
    .pop           (pop),
    .head_valid    (head_valid),
    .head          (head)
  );

  rvx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .stat       (bk_stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_status       = res.status;
  assign out_pc_after     = res.pc_after;
  assign out_read_word    = res.read_word;
  assign out_dest_written = res.dest_written;
  assign out_dest_index   = res.dest_index;
  assign out_dest_value   = res.dest_value;

  `RVX_ASSERT_IMP(a_clear_blocks_input, bk_stat.clearing, in_stall, "beat accepted during clear")
  `RVX_ASSERT_NXT(a_halt_sticky, bk_stat.halted, bk_stat.halted, "halted flag dropped")
  `RVX_ASSERT_IMP(a_halted_status, out_valid && out_status == ST_HALTED, bk_stat.halted, "halted status without halt")

endmodule

`default_nettype wire
